FILE: sv/spl_pkg.sv
package spl_pkg;

    // Field widths of the sample and level paths.
    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 16;
    localparam int FRAC_BITS = 15;
    localparam int HELD_W    = LEVEL_W + FRAC_BITS;
    localparam int DECAY_W   = 16;
    localparam int FLY_W     = 16;

    // Default decimation of the frames that count within a block.
    localparam int DECIMATION_DEF = 3;

    // Configuration port geometry: four 32-bit registers at 4*i.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_STEREO_IN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEREO_OUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DECAY      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FLY_BACK   = 2'd3;

    // Register values after reset.
    localparam logic               STEREO_IN_RST  = 1'b1;
    localparam logic               STEREO_OUT_RST = 1'b1;
    localparam logic [DECAY_W-1:0] DECAY_RST      = 16'd64880;
    localparam logic [FLY_W-1:0]   FLY_BACK_RST   = 16'd2;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic               stereo_in;
        logic               stereo_out;
        logic [DECAY_W-1:0] decay_factor;
        logic [FLY_W-1:0]   fly_back_level;
    } spl_cfg_t;

    // A closed block waiting for the level stage.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] min_left;
        logic signed [SAMPLE_W-1:0] min_right;
    } spl_close_t;

endpackage

FILE: sv/stereo_peak_level_meter.sv
// Channel   Handshake                     Contents
// s_        s_tvalid / s_tready           tdata: sample_left, sample_right; tlast: last_of_block
// m_        m_tvalid / m_tready           tdata: level_left, level_right
// APB       psel, penable, pwrite, pready stereo_in, stereo_out, decay_factor, fly_back_level
//
// One frame is taken every clock cycle unless input stalls. A frame that closes a block
// passes its result on in turn: the minima are merged into a block register, then the
// per-channel level stage applies the decay multiply and loads the output register.
// While the output register is full and not taken, a further closing block waits in
// the block register and input stalls only once both are occupied.
// Reset (aresetn, synchronous, active low) clears minima, phase, levels and valid flags and loads config defaults.
module stereo_peak_level_meter
    import spl_pkg::*;
#(
    parameter int DECIMATION = DECIMATION_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input frames.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] sample_left, [31:16] sample_right
    input  logic                  s_tlast,   // last_of_block
    // Block levels.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [15:0] level_left, [31:16] level_right
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(DECIMATION - 1);

    spl_cfg_t            cfg_reg;
    spl_cfg_t            cfg_next;
    logic                cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;

    logic                take;
    logic                on_grid;
    logic                advance;
    spl_close_t          close_blk;

    logic signed [SAMPLE_W-1:0] min_left_eff;
    logic signed [SAMPLE_W-1:0] min_right_eff;
    logic [LEVEL_W-1:0]  level_left_next;
    logic [LEVEL_W-1:0]  level_right_next;

    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [31:0]         m_tdata_reg;
    logic [31:0]         m_tdata_next;

    // Configuration writes and read-back.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_STEREO_IN:  cfg_next.stereo_in      = pwdata[0];
                REG_STEREO_OUT: cfg_next.stereo_out     = pwdata[0];
                REG_DECAY:      cfg_next.decay_factor   = pwdata[DECAY_W-1:0];
                REG_FLY_BACK:   cfg_next.fly_back_level = pwdata[FLY_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STEREO_IN:  prdata = APB_DATA_W'(cfg_reg.stereo_in);
            REG_STEREO_OUT: prdata = APB_DATA_W'(cfg_reg.stereo_out);
            REG_DECAY:      prdata = APB_DATA_W'(cfg_reg.decay_factor);
            REG_FLY_BACK:   prdata = APB_DATA_W'(cfg_reg.fly_back_level);
            default:        prdata = '0;
        endcase
    end

    // Handshake: a new frame enters unless a closed block is stuck behind a full output.
    assign advance  = close_blk.valid && (!m_tvalid_reg || m_tready);
    assign s_tready = !close_blk.valid || !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign on_grid  = (phase_reg == '0);

    // Position within the decimation cycle; a block close restarts it.
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            if (s_tlast || (phase_reg == PHASE_LAST)) begin
                phase_next = '0;
            end else begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    // Per-channel minimum lanes.
    spl_lane_min u_min_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .sample_en (on_grid),
        .close     (s_tlast),
        .sample    (s_tdata[15:0]),
        .min_eff   (min_left_eff)
    );

    spl_lane_min u_min_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .sample_en (on_grid && cfg_reg.stereo_in),
        .close     (s_tlast),
        .sample    (s_tdata[31:16]),
        .min_eff   (min_right_eff)
    );

    // Merge of the lane minima at block close.
    spl_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .last          (s_tlast),
        .advance       (advance),
        .cfg           (cfg_reg),
        .min_left_eff  (min_left_eff),
        .min_right_eff (min_right_eff),
        .close_o       (close_blk)
    );

    // Per-channel held levels; the right level freezes under mono output.
    spl_level u_level_left (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .update         (advance),
        .block_min      (close_blk.min_left),
        .decay_factor   (cfg_reg.decay_factor),
        .fly_back_level (cfg_reg.fly_back_level),
        .level_next     (level_left_next)
    );

    spl_level u_level_right (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .update         (advance && cfg_reg.stereo_out),
        .block_min      (close_blk.min_right),
        .decay_factor   (cfg_reg.decay_factor),
        .fly_back_level (cfg_reg.fly_back_level),
        .level_next     (level_right_next)
    );

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (advance) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {level_right_next, level_left_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stereo_in      <= STEREO_IN_RST;
            cfg_reg.stereo_out     <= STEREO_OUT_RST;
            cfg_reg.decay_factor   <= DECAY_RST;
            cfg_reg.fly_back_level <= FLY_BACK_RST;
            phase_reg              <= '0;
            m_tvalid_reg           <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/spl_lane_min.sv
module spl_lane_min
    import spl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic                       sample_en,
    input  logic                       close,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0] min_eff
);

    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] min_next;

    // Running minimum including the sample of the current frame.
    assign min_eff = (sample_en && (sample < min_reg)) ? sample : min_reg;

    // The minimum restarts from zero once the block has closed.
    always_comb begin
        min_next = min_reg;
        if (take) begin
            min_next = close ? '0 : min_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= '0;
        end else begin
            min_reg <= min_next;
        end
    end

endmodule

FILE: sv/spl_merge.sv
module spl_merge
    import spl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic                       last,
    input  logic                       advance,
    input  spl_cfg_t                   cfg,
    input  logic signed [SAMPLE_W-1:0] min_left_eff,
    input  logic signed [SAMPLE_W-1:0] min_right_eff,
    output spl_close_t                 close_o
);

    spl_close_t close_reg;
    spl_close_t close_next;
    logic signed [SAMPLE_W-1:0] min_left_m;

    // With stereo input and mono output the left level follows the smaller of both minima.
    assign min_left_m = (cfg.stereo_in && !cfg.stereo_out && (min_right_eff < min_left_eff))
                        ? min_right_eff : min_left_eff;

    // Capture a closing block; release the slot once the level stage takes it.
    always_comb begin
        close_next = close_reg;
        if (take && last) begin
            close_next.valid     = 1'b1;
            close_next.min_left  = min_left_m;
            close_next.min_right = min_right_eff;
        end else if (advance) begin
            close_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_reg.valid <= 1'b0;
        end else begin
            close_reg.valid <= close_next.valid;
        end
        close_reg.min_left  <= close_next.min_left;
        close_reg.min_right <= close_next.min_right;
    end

    assign close_o = close_reg;

endmodule

FILE: sv/spl_level.sv
module spl_level
    import spl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       update,
    input  logic signed [SAMPLE_W-1:0] block_min,
    input  logic [DECAY_W-1:0]         decay_factor,
    input  logic [FLY_W-1:0]           fly_back_level,
    output logic [LEVEL_W-1:0]         level_next
);

    localparam int PROD_W = HELD_W + DECAY_W;

    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;
    logic [PROD_W-1:0]   product;
    logic [HELD_W-1:0]   decayed;
    logic [HELD_W-1:0]   thresh;
    logic [HELD_W-1:0]   peak;
    logic [HELD_W-1:0]   new_level;
    logic [SAMPLE_W:0]   neg_min;

    // Negated minimum as a Q16.15 peak; the most negative sample gives 32768.
    assign neg_min = -{block_min[SAMPLE_W-1], block_min};
    assign peak    = {neg_min[LEVEL_W-1:0], {FRAC_BITS{1'b0}}};

    // Decay by the Q0.16 factor, truncating; below the fly-back level snap to zero.
    assign product   = PROD_W'(held_reg) * PROD_W'(decay_factor);
    assign thresh    = {fly_back_level, {FRAC_BITS{1'b0}}};
    assign decayed   = (held_reg >= thresh) ? product[PROD_W-1:DECAY_W] : '0;
    assign new_level = (peak > decayed) ? peak : decayed;

    assign held_next  = update ? new_level : held_reg;
    assign level_next = held_next[HELD_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

endmodule
